// ===== rtl/pfla_pkg.sv =====
// ----------------------------------------------------------------------------
// pfla_pkg
// Shared types, field widths and codes of the page free-list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfla_pkg;

   // default sizing
   localparam int unsigned PAGE_TOTAL_DEF  = 1024;
   localparam int unsigned MAX_REQUEST_DEF = 64;

   // field widths
   localparam int unsigned OPCODE_W  = 1;
   localparam int unsigned COUNT_W   = 7;
   localparam int unsigned OWNER_W   = 32;
   localparam int unsigned PAGE_W    = 10;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned RESERVE_W = 11;

   // descriptor word: {owner, used}
   localparam int unsigned DESC_W = OWNER_W + 1;

   // width used for index range compares (covers 65536 pages)
   localparam int unsigned RANGE_W = 17;

   // operation codes
   localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_FREE  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOSPACE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_IDLE    = 2'd2;

   // admission check outcome
   typedef struct packed {
      logic alloc_ok;
      logic idx_ok;
   } check_type;

endpackage

`default_nettype wire

// ===== rtl/pfla_req_if.sv =====
// ----------------------------------------------------------------------------
// pfla_req_if
// Request channel: allocate or free items with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfla_req_if
   import pfla_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [COUNT_W-1:0]  page_count;
   logic [OWNER_W-1:0]  owner_ino;
   logic [PAGE_W-1:0]   page_index;

   modport source (output valid, output opcode, output page_count,
                   output owner_ino, output page_index, input ready);
   modport sink   (input valid, input opcode, input page_count,
                   input owner_ino, input page_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/pfla_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pfla_rsp_if
// Response channel: one transfer per granted page, per free request and per refused allocation.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfla_rsp_if
   import pfla_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [PAGE_W-1:0]   granted_page;
   logic                last;

   modport source (output valid, output status, output granted_page,
                   output last, input ready);
   modport sink   (input valid, input status, input granted_page,
                   input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/pfla_ram.sv =====
// ----------------------------------------------------------------------------
// pfla_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pfla_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/pfla_check.sv =====
// ----------------------------------------------------------------------------
// pfla_check
// Admission compare unit: request size and reserve check for allocations,
// page index range check for frees.
// ----------------------------------------------------------------------------
`default_nettype none

module pfla_check
   import pfla_pkg::*;
#(
   parameter int unsigned PAGE_TOTAL  = PAGE_TOTAL_DEF,
   parameter int unsigned MAX_REQUEST = MAX_REQUEST_DEF,
   localparam int unsigned CNTW = $clog2(PAGE_TOTAL + 1),
   localparam int unsigned SUMW = ((CNTW > RESERVE_W) ? CNTW : RESERVE_W) + 1
) (
   input  wire logic [CNTW-1:0]      free_count,
   input  wire logic [RESERVE_W-1:0] reserve_pages,
   input  wire logic [COUNT_W-1:0]   page_count,
   input  wire logic [PAGE_W-1:0]    page_index,
   output check_type                 check
);

   logic [SUMW-1:0] need;
   logic [SUMW-1:0] have;
   logic            size_ok;

   // pages needed = reserve + request, compared against the free count
   assign need    = SUMW'(reserve_pages) + SUMW'(page_count);
   assign have    = SUMW'(free_count);
   assign size_ok = (page_count != '0) && (page_count <= COUNT_W'(MAX_REQUEST));

   assign check.alloc_ok = size_ok && (have >= need);
   assign check.idx_ok   = RANGE_W'(page_index) < RANGE_W'(PAGE_TOTAL);

endmodule

`default_nettype wire

// ===== rtl/page_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// page_free_list_allocator
// Page allocator over a FIFO free list with a per-page descriptor table.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass that loads the free list with
// every page index in ascending order and marks every descriptor idle with
// owner 0; req.ready stays low during that pass, while csr writes are taken.
// A free item reads the descriptor, then checks and updates it. An allocate
// item that passes the size and reserve check is accepted, then each page
// needs one free-list RAM read followed by a descriptor write and one response
// transfer. A refused allocation loads its single response into the output
// register in the accept cycle. One item is in work at a time; a pending
// response that is not taken stalls the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module page_free_list_allocator
   import pfla_pkg::*;
#(
   parameter int unsigned PAGE_TOTAL  = PAGE_TOTAL_DEF,
   parameter int unsigned MAX_REQUEST = MAX_REQUEST_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   pfla_req_if.sink                  req,
   pfla_rsp_if.source                rsp,
   input  wire logic                 csr_wr_en,
   input  wire logic [RESERVE_W-1:0] csr_wr_data
);

   localparam int unsigned PW   = $clog2(PAGE_TOTAL);
   localparam int unsigned CNTW = $clog2(PAGE_TOTAL + 1);
   localparam int unsigned REQW = $clog2(MAX_REQUEST + 1);
   localparam logic [PW-1:0]   LAST_SLOT = PW'(PAGE_TOTAL - 1);
   localparam logic [CNTW-1:0] ALL_FREE  = CNTW'(PAGE_TOTAL);

   // sequencer states
   localparam logic [2:0] ST_CLEAR    = 3'd0;
   localparam logic [2:0] ST_IDLE     = 3'd1;
   localparam logic [2:0] ST_ALLOC_RD = 3'd2;
   localparam logic [2:0] ST_ALLOC_WR = 3'd3;
   localparam logic [2:0] ST_FREE_CHK = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [PW-1:0]        clr_ff, clr_in;
   logic [PW-1:0]        head_ff, head_in;
   logic [PW-1:0]        tail_ff, tail_in;
   logic [CNTW-1:0]      count_ff, count_in;
   logic [REQW-1:0]      remain_ff, remain_in;
   logic [OWNER_W-1:0]   ino_ff, ino_in;
   logic [PAGE_W-1:0]    idx_ff, idx_in;
   logic                 idx_ok_ff, idx_ok_in;
   logic [RESERVE_W-1:0] reserve_ff, reserve_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [PAGE_W-1:0]    rsp_page_ff, rsp_page_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 out_free;
   logic                 req_ready;
   check_type            chk;

   logic [PW-1:0]        req_addr;
   logic [PAGE_W-1:0]    pop_page;
   logic [PW-1:0]        idx_addr;

   logic                 fifo_we, fifo_re;
   logic [PW-1:0]        fifo_wa, fifo_wd, fifo_ra, fifo_rd;
   logic                 desc_we, desc_re;
   logic [PW-1:0]        desc_wa, desc_ra;
   logic [DESC_W-1:0]    desc_wd, desc_rd;

   // width adaption between page fields and internal page indices
   if (PW >= PAGE_W) begin : g_wide
      assign req_addr = PW'(req.page_index);
      assign pop_page = fifo_rd[PAGE_W-1:0];
      assign idx_addr = PW'(idx_ff);
   end else begin : g_narrow
      assign req_addr = req.page_index[PW-1:0];
      assign pop_page = PAGE_W'(fifo_rd);
      assign idx_addr = idx_ff[PW-1:0];
   end

   // free list of page indices
   pfla_ram #(
      .WIDTH (PW),
      .DEPTH (PAGE_TOTAL)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (fifo_we),
      .wr_addr (fifo_wa),
      .wr_data (fifo_wd),
      .rd_en   (fifo_re),
      .rd_addr (fifo_ra),
      .rd_data (fifo_rd)
   );

   // descriptor table: {owner, used}
   pfla_ram #(
      .WIDTH (DESC_W),
      .DEPTH (PAGE_TOTAL)
   ) u_desc_ram (
      .clock   (clock),
      .wr_en   (desc_we),
      .wr_addr (desc_wa),
      .wr_data (desc_wd),
      .rd_en   (desc_re),
      .rd_addr (desc_ra),
      .rd_data (desc_rd)
   );

   // admission compare unit
   pfla_check #(
      .PAGE_TOTAL  (PAGE_TOTAL),
      .MAX_REQUEST (MAX_REQUEST)
   ) u_check (
      .free_count    (count_ff),
      .reserve_pages (reserve_ff),
      .page_count    (req.page_count),
      .page_index    (req.page_index),
      .check         (chk)
   );

   // output register can take a new result
   assign out_free = !rsp_valid_ff || rsp.ready;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      remain_in     = remain_ff;
      ino_in        = ino_ff;
      idx_in        = idx_ff;
      idx_ok_in     = idx_ok_ff;
      reserve_in    = reserve_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_last_in   = rsp_last_ff;
      req_ready     = 1'b0;
      fifo_we       = 1'b0;
      fifo_wa       = tail_ff;
      fifo_wd       = idx_addr;
      fifo_re       = 1'b0;
      fifo_ra       = head_ff;
      desc_we       = 1'b0;
      desc_wa       = idx_addr;
      desc_wd       = '0;
      desc_re       = 1'b0;
      desc_ra       = req_addr;

      if (csr_wr_en) begin
         reserve_in = csr_wr_data;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            // load slot i with index i, descriptor idle
            fifo_we = 1'b1;
            fifo_wa = clr_ff;
            fifo_wd = clr_ff;
            desc_we = 1'b1;
            desc_wa = clr_ff;
            desc_wd = '0;
            clr_in  = clr_ff + PW'(1);
            if (clr_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = out_free;
            if (req.valid && out_free) begin
               if (req.opcode == OP_ALLOC) begin
                  if (chk.alloc_ok) begin
                     remain_in = req.page_count[REQW-1:0];
                     ino_in    = req.owner_ino;
                     state_in  = ST_ALLOC_RD;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_NOSPACE;
                     rsp_page_in   = '0;
                     rsp_last_in   = 1'b1;
                  end
               end else begin
                  idx_in    = req.page_index;
                  idx_ok_in = chk.idx_ok;
                  desc_re   = chk.idx_ok;
                  state_in  = ST_FREE_CHK;
               end
            end
         end
         ST_ALLOC_RD: begin
            fifo_re  = 1'b1;
            fifo_ra  = head_ff;
            state_in = ST_ALLOC_WR;
         end
         ST_ALLOC_WR: begin
            if (out_free) begin
               desc_we       = 1'b1;
               desc_wa       = fifo_rd;
               desc_wd       = {ino_ff, 1'b1};
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_page_in   = pop_page;
               rsp_last_in   = (remain_ff == REQW'(1));
               head_in       = (head_ff == LAST_SLOT) ? '0 : head_ff + PW'(1);
               count_in      = count_ff - CNTW'(1);
               remain_in     = remain_ff - REQW'(1);
               state_in      = (remain_ff == REQW'(1)) ? ST_IDLE : ST_ALLOC_RD;
            end
         end
         ST_FREE_CHK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_page_in  = idx_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
               if (idx_ok_ff && desc_rd[0]) begin
                  // return the page at the tail, mark idle with owner 0
                  fifo_we       = 1'b1;
                  fifo_wa       = tail_ff;
                  fifo_wd       = idx_addr;
                  desc_we       = 1'b1;
                  desc_wa       = idx_addr;
                  desc_wd       = '0;
                  tail_in       = (tail_ff == LAST_SLOT) ? '0 : tail_ff + PW'(1);
                  count_in      = count_ff + CNTW'(1);
                  rsp_status_in = STATUS_OK;
               end else begin
                  rsp_status_in = STATUS_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= ALL_FREE;
         remain_ff    <= '0;
         idx_ok_ff    <= 1'b0;
         reserve_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         idx_ok_ff    <= idx_ok_in;
         reserve_ff   <= reserve_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ino_ff        <= ino_in;
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req.ready        = req_ready;
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.granted_page = rsp_page_ff;
   assign rsp.last         = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/pfla_checker.sv =====
// ----------------------------------------------------------------------------
// pfla_checker
// Port-level assertions for the page allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pfla_checker
   import pfla_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic [PAGE_W-1:0]   rsp_page,
   input wire logic                rsp_last
);

   // a stalled response holds its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
                                  $stable(rsp_page) && $stable(rsp_last))
      else $error("response changed while stalled");

   // no new request is taken while a response is backed up
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response stalled");

   // clearing pass keeps the request side closed after reset
   a_clear_closed: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request ready right after reset");

   // refusals and idle frees are single, final transfers
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_NOSPACE || rsp_status == STATUS_IDLE)
      |-> rsp_last && (rsp_status != STATUS_NOSPACE || rsp_page == '0))
      else $error("malformed refusal response");

   // a request transfer needs room in the output register
   a_ready_needs_idle_out: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid || rsp_ready)
      else $error("request transfer with blocked output");

endmodule

bind page_free_list_allocator pfla_checker u_pfla_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req.valid),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_status (rsp.status),
   .rsp_page   (rsp.granted_page),
   .rsp_last   (rsp.last)
);

`default_nettype wire
